>>> sv/pbcc_pkg.sv
// shared types and constants of the pairwise base co-occurrence counter
// field widths, stream packing offsets, sequencer states and ram control
// no dependencies
`default_nettype none

package pbcc_pkg;

  // fixed field widths of the stream items
  localparam int unsigned POS_W    = 7;
  localparam int unsigned BASE_W   = 2;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned QROW_W   = 11;
  localparam int unsigned QPAIR_W  = 4;
  localparam int unsigned OUT_W    = 32;

  // input tdata packing, lowest bit first, padded to whole bytes
  localparam int unsigned POS_LSB    = 0;
  localparam int unsigned BASE_LSB   = POS_LSB + POS_W;
  localparam int unsigned BVALID_LSB = BASE_LSB + BASE_W;
  localparam int unsigned WEIGHT_LSB = BVALID_LSB + 1;
  localparam int unsigned QROW_LSB   = WEIGHT_LSB + WEIGHT_W;
  localparam int unsigned QPAIR_LSB  = QROW_LSB + QROW_W;
  localparam int unsigned IN_TDATA_W = 48;

  // request kind carried in tuser
  typedef enum logic {
    REQ_ELEMENT = 1'b0,
    REQ_QUERY   = 1'b1
  } pbcc_req_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAIR,
    ST_QUERY
  } pbcc_state_e;

  // counter ram access strobes
  typedef struct packed {
    logic rd_en;
    logic add_en;
  } pbcc_ram_ctrl_t;

endpackage

`default_nettype wire

>>> sv/pbcc_read_buf.sv
// buffer of the usable elements of the current read, with fill count and weight
// each entry keeps position, base and the first row index of its position
// depends on pbcc_pkg
`default_nettype none

module pbcc_read_buf #(
  parameter int unsigned REF_LEN = 64,
  parameter int unsigned ROW_W   = 11,
  parameter int unsigned FILL_W  = 7,
  parameter int unsigned IDX_W   = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          elem_fire_i,
  input  logic [pbcc_pkg::POS_W-1:0]    position_i,
  input  logic [pbcc_pkg::BASE_W-1:0]   base_code_i,
  input  logic                          base_valid_i,
  input  logic                          read_end_i,
  input  logic [pbcc_pkg::WEIGHT_W-1:0] weight_i,
  input  logic                          rd_en_i,
  input  logic [IDX_W-1:0]              rd_idx_i,
  output logic                          take_o,
  output logic [FILL_W-1:0]             npairs_o,
  output logic [pbcc_pkg::WEIGHT_W-1:0] weight_o,
  output logic [ROW_W-1:0]              rd_start_o,
  output logic [pbcc_pkg::POS_W-1:0]    rd_pos_o,
  output logic [pbcc_pkg::BASE_W-1:0]   rd_base_o
);
  import pbcc_pkg::*;

  localparam int unsigned PX_W  = ($clog2(REF_LEN + 1) > POS_W) ? $clog2(REF_LEN + 1) : POS_W;
  localparam int unsigned BUF_W = ROW_W + POS_W + BASE_W;
  localparam int unsigned MUL_W = ROW_W + 1;

  logic [BUF_W-1:0]    buf_mem [REF_LEN];
  logic [BUF_W-1:0]    rd_word_q;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic [POS_W-1:0]    last_pos_q;
  logic                open_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [POS_W-1:0]    pos_m1;
  logic [MUL_W-1:0]    tri_prod;
  logic [ROW_W-1:0]    start_row;

  // element is buffered when valid, in range, room left and position rising
  always_comb begin
    take_o = base_valid_i && (position_i != '0) &&
             (PX_W'(position_i) <= PX_W'(REF_LEN)) &&
             (fill_q < FILL_W'(REF_LEN)) &&
             ((fill_q == '0) || (position_i > last_pos_q));
  end

  // first row of position p: i*(2*REF_LEN-1-i)/2 with i = p-1
  always_comb begin
    pos_m1    = position_i - POS_W'(1);
    tri_prod  = MUL_W'(pos_m1) * (MUL_W'(2 * REF_LEN - 1) - MUL_W'(pos_m1));
    start_row = tri_prod[MUL_W-1:1];
  end

  // fill count: one more per buffered element, emptied at read end
  always_comb begin
    fill_d = fill_q;
    if (elem_fire_i) begin
      if (read_end_i) begin
        fill_d = '0;
      end else if (take_o) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      open_q   <= 1'b0;
      weight_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (elem_fire_i) begin
        open_q <= !read_end_i;
        if (!open_q) begin
          weight_q <= weight_i;
        end
      end
    end
  end

  // last buffered position
  always_ff @(posedge clk_i) begin
    if (elem_fire_i && take_o) begin
      last_pos_q <= position_i;
    end
  end

  // buffer memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (elem_fire_i && take_o) begin
      buf_mem[fill_q[IDX_W-1:0]] <= {start_row, position_i, base_code_i};
    end
    if (rd_en_i) begin
      rd_word_q <= buf_mem[rd_idx_i];
    end
  end

  assign npairs_o   = fill_q;
  assign weight_o   = weight_q;
  assign rd_start_o = rd_word_q[BUF_W-1 -: ROW_W];
  assign rd_pos_o   = rd_word_q[BASE_W +: POS_W];
  assign rd_base_o  = rd_word_q[BASE_W-1:0];

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(REF_LEN))
    else $error("buffer fill beyond depth");
  a_closed_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> fill_q == '0)
    else $error("buffer holds elements outside a read");
  a_read_end_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_fire_i && read_end_i |=> fill_q == '0 && !open_q)
    else $error("read end did not empty the buffer");
`endif

endmodule

`default_nettype wire

>>> sv/pbcc_count_ram.sv
// counter memory with clearing sweep after reset and saturating add write-back
// read data registered; the add uses the last read word
// depends on pbcc_pkg
`default_nettype none

module pbcc_count_ram #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned ADDR_W      = 15,
  parameter int unsigned DEPTH       = 32256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pbcc_pkg::pbcc_ram_ctrl_t       ctrl_i,
  input  logic [ADDR_W-1:0]              rd_addr_i,
  input  logic [ADDR_W-1:0]              wr_addr_i,
  input  logic [pbcc_pkg::WEIGHT_W-1:0]  weight_i,
  output logic [COUNT_WIDTH-1:0]         rd_data_o,
  output logic                           clr_busy_o
);
  import pbcc_pkg::*;

  localparam int unsigned SUM_W = ((COUNT_WIDTH > WEIGHT_W) ? COUNT_WIDTH : WEIGHT_W) + 1;

  logic [COUNT_WIDTH-1:0] cnt_mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rd_data_q;
  logic [ADDR_W-1:0]      clr_q;
  logic                   clr_busy_q;
  logic [SUM_W-1:0]       sum;
  logic                   sat;
  logic [COUNT_WIDTH-1:0] add_data;

  // saturating add of the weight to the last read word
  always_comb begin
    sum      = SUM_W'(rd_data_q) + SUM_W'(weight_i);
    sat      = sum > SUM_W'({COUNT_WIDTH{1'b1}});
    add_data = sat ? '1 : sum[COUNT_WIDTH-1:0];
  end

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_q <= clr_q + ADDR_W'(1);
      if (clr_q == ADDR_W'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      cnt_mem[clr_q] <= '0;
    end else if (ctrl_i.add_en) begin
      cnt_mem[wr_addr_i] <= add_data;
    end
    if (ctrl_i.rd_en) begin
      rd_data_q <= cnt_mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clr_busy_o = clr_busy_q;

`ifndef SYNTHESIS
  a_clear_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> clr_q <= ADDR_W'(DEPTH - 1))
    else $error("clearing sweep beyond memory depth");
  a_no_access_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !ctrl_i.rd_en && !ctrl_i.add_en)
    else $error("counter access during clearing sweep");
  a_add_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.add_en |-> $past(ctrl_i.rd_en))
    else $error("write-back without a preceding read");
`endif

endmodule

`default_nettype wire

>>> sv/pairwise_base_cooccurrence_counter_core.sv
// query: result via the counter ram read register and the output register; input waits
// until the result is loaded, and a finished result may wait while elements are taken
// element: with n usable elements buffered before it, input waits while its n counter
// read-modify-writes, one per pair, pass the ram read and write ports; none if n is 0
// reset: asynchronous, then a sweep clears REF_LEN*(REF_LEN-1)*8 entries, input held off
// depends on pbcc_pkg, pbcc_read_buf, pbcc_count_ram
`default_nettype none

module pairwise_base_cooccurrence_counter_core #(
  parameter int unsigned REF_LEN     = 64,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // position[6:0], base_code[8:7], base_valid[9], weight[25:10],
  // query_row[36:26], query_pair[40:37], zero[47:41]
  input  logic [pbcc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // req_type
  input  logic                              s_axis_tuser,
  // read_end
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // count_value[31:0]
  output logic [pbcc_pkg::OUT_W-1:0]        m_axis_tdata
);
  import pbcc_pkg::*;

  localparam int unsigned NUM_ROWS = REF_LEN * (REF_LEN - 1) / 2;
  localparam int unsigned ROW_W    = $clog2(NUM_ROWS + 1);
  localparam int unsigned ADDR_W   = ROW_W + QPAIR_W;
  localparam int unsigned DEPTH    = NUM_ROWS * 16;
  localparam int unsigned IDX_W    = $clog2(REF_LEN);
  localparam int unsigned FILL_W   = $clog2(REF_LEN + 1);
  localparam int unsigned QX_W     = (ROW_W > QROW_W) ? ROW_W : QROW_W;

  pbcc_state_e          state_q, state_d;
  pbcc_ram_ctrl_t       ram_ctrl;

  logic [POS_W-1:0]     position;
  logic [BASE_W-1:0]    base_code;
  logic                 base_valid;
  logic [WEIGHT_W-1:0]  weight;
  logic [QROW_W-1:0]    query_row;
  logic [QPAIR_W-1:0]   query_pair;

  logic                 s_fire, elem_fire, query_fire;
  logic                 take;
  logic [FILL_W-1:0]    npairs;
  logic [WEIGHT_W-1:0]  read_weight;
  logic [ROW_W-1:0]     rd_start;
  logic [POS_W-1:0]     rd_pos;
  logic [BASE_W-1:0]    rd_base;

  logic [FILL_W-1:0]    iss_q, npairs_q;
  logic [POS_W-1:0]     cur_pos_q;
  logic [BASE_W-1:0]    cur_base_q;
  logic                 s1_q, s2_q;
  logic [ADDR_W-1:0]    s2_addr_q;
  logic                 issue;
  logic [ROW_W-1:0]     pair_row;
  logic [ADDR_W-1:0]    pair_addr;

  logic [QX_W-1:0]      qrow_x;
  logic                 q_in_range, q_in_range_q;
  logic [ADDR_W-1:0]    q_addr;
  logic [ADDR_W-1:0]    ram_rd_addr;
  logic [COUNT_WIDTH-1:0] ram_rd_data;
  logic                 clr_busy;

  logic                 out_load;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_W-1:0]     out_data_q, out_data_d;

  // unpack the input transfer
  assign position   = s_axis_tdata[POS_LSB +: POS_W];
  assign base_code  = s_axis_tdata[BASE_LSB +: BASE_W];
  assign base_valid = s_axis_tdata[BVALID_LSB];
  assign weight     = s_axis_tdata[WEIGHT_LSB +: WEIGHT_W];
  assign query_row  = s_axis_tdata[QROW_LSB +: QROW_W];
  assign query_pair = s_axis_tdata[QPAIR_LSB +: QPAIR_W];

  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign elem_fire  = s_fire && (pbcc_req_e'(s_axis_tuser) == REQ_ELEMENT);
  assign query_fire = s_fire && (pbcc_req_e'(s_axis_tuser) == REQ_QUERY);

  // query address and range check
  always_comb begin
    qrow_x     = QX_W'(query_row);
    q_in_range = qrow_x < QX_W'(NUM_ROWS);
    q_addr     = {qrow_x[ROW_W-1:0], query_pair};
  end

  // pair address from the buffered element and the current one
  always_comb begin
    issue     = (state_q == ST_PAIR) && (iss_q != npairs_q);
    pair_row  = rd_start + ROW_W'(cur_pos_q - rd_pos - POS_W'(1));
    pair_addr = {pair_row, rd_base, cur_base_q};
  end

  assign out_load = (state_q == ST_QUERY) && (!out_valid_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (!clr_busy) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        priority if (query_fire) begin
          state_d = ST_QUERY;
        end else if (elem_fire && take && (npairs != '0)) begin
          state_d = ST_PAIR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAIR: begin
        if (!issue && !s1_q && !s2_q) state_d = ST_IDLE;
      end
      ST_QUERY: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready   = 1'b0;
    ram_ctrl.rd_en  = 1'b0;
    ram_ctrl.add_en = s2_q;
    ram_rd_addr     = pair_addr;
    unique case (state_q)
      ST_CLEAR: begin
        s_axis_tready = 1'b0;
      end
      ST_IDLE: begin
        s_axis_tready  = 1'b1;
        ram_ctrl.rd_en = query_fire;
        ram_rd_addr    = q_addr;
      end
      ST_PAIR: begin
        ram_ctrl.rd_en = s1_q;
      end
      ST_QUERY: begin
        s_axis_tready = 1'b0;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = q_in_range_q ? OUT_W'(ram_rd_data) : '0;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      iss_q       <= '0;
      npairs_q    <= '0;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s1_q        <= issue;
      s2_q        <= s1_q;
      out_valid_q <= out_valid_d;
      if (elem_fire) begin
        iss_q    <= '0;
        npairs_q <= take ? npairs : '0;
      end else if (issue) begin
        iss_q <= iss_q + FILL_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (elem_fire) begin
      cur_pos_q  <= position;
      cur_base_q <= base_code;
    end
    if (query_fire) begin
      q_in_range_q <= q_in_range;
    end
    if (s1_q) begin
      s2_addr_q <= pair_addr;
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  pbcc_read_buf #(
    .REF_LEN (REF_LEN),
    .ROW_W   (ROW_W),
    .FILL_W  (FILL_W),
    .IDX_W   (IDX_W)
  ) u_read_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .elem_fire_i  (elem_fire),
    .position_i   (position),
    .base_code_i  (base_code),
    .base_valid_i (base_valid),
    .read_end_i   (s_axis_tlast),
    .weight_i     (weight),
    .rd_en_i      (issue),
    .rd_idx_i     (iss_q[IDX_W-1:0]),
    .take_o       (take),
    .npairs_o     (npairs),
    .weight_o     (read_weight),
    .rd_start_o   (rd_start),
    .rd_pos_o     (rd_pos),
    .rd_base_o    (rd_base)
  );

  pbcc_count_ram #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .ADDR_W      (ADDR_W),
    .DEPTH       (DEPTH)
  ) u_count_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ram_ctrl),
    .rd_addr_i  (ram_rd_addr),
    .wr_addr_i  (s2_addr_q),
    .weight_i   (read_weight),
    .rd_data_o  (ram_rd_data),
    .clr_busy_o (clr_busy)
  );

`ifndef SYNTHESIS
  a_rmw_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_ctrl.rd_en && ram_ctrl.add_en |-> ram_rd_addr != s2_addr_q)
    else $error("counter read and write-back hit the same entry");
  a_issue_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_q <= npairs_q)
    else $error("pair issue count beyond buffered elements");
  a_query_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QUERY) && ($past(state_q) != ST_QUERY) |-> $past(query_fire))
    else $error("query state entered without a query transfer");
  a_pair_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !s1_q && !s2_q)
    else $error("idle with pair accesses still in flight");
`endif

endmodule

`default_nettype wire
